// ===== rtl/core/iws_pkg.sv =====
// ----------------------------------------------------------------------------
// iws_pkg
// Shared types and constants for the IR wall sensing block.
// ----------------------------------------------------------------------------
package iws_pkg;

  localparam int SMP_W = 12;
  localparam int LEN_W = 8;
  localparam int ERR_W = 13;
  localparam int NUM_W = 24;
  localparam int DEN_W = 12;

  localparam logic [SMP_W-1:0] FRONT_THR_RST = 12'd960;
  localparam logic [SMP_W-1:0] SIDE_THR_RST  = 12'd800;

  localparam logic [0:0] REG_FRONT_THR = 1'b0;
  localparam logic [0:0] REG_SIDE_THR  = 1'b1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TABLE  = 1'b1;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_STRAIGHT = 2'd1;
  localparam logic [1:0] MODE_DIAGONAL = 2'd2;

  localparam logic [2:0] SEL_FRONT_LEN = 3'd4;
  localparam logic [2:0] SEL_SIDE_LEN  = 3'd5;

  localparam logic [ERR_W-1:0] STRAIGHT_TARGET = 13'd720;
  localparam logic [ERR_W-1:0] DIAG_TARGET     = 13'd512;
  localparam logic [ERR_W-1:0] FRONT_MARGIN    = 13'd160;
  localparam logic [SMP_W-1:0] DIAG_FRONT_MIN  = 12'd1280;
  localparam logic [SMP_W-1:0] STABLE_DIFF     = 12'd80;
  localparam logic [7:0]       STABLE_MIN      = 8'd10;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/iws_div.sv =====
// ----------------------------------------------------------------------------
// iws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iws_div (
  input  logic              clk,
  input  logic              rst_n,
  input  iws_pkg::div_req_t req,
  output iws_pkg::div_rsp_t rsp
);
  import iws_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/core/ir_wall_sensing.sv =====
// ----------------------------------------------------------------------------
// ir_wall_sensing
// IR distance conversion with moving average, wall flags and side control.
//
//   channel  direction  handshake          contents
//   in_      in         in_valid/in_stall  sample set or table write
//   out_     out        out_valid/out_stall distances, flags, errors
//   cfg      in/out     apb psel/penable   two threshold registers
//
// a table write never raises in_stall; how long a sample set takes to its result is
// set by the linear table scan and the 24-step shared divider
// reset clears the averages, counters and held control; tables are not cleared
// history reads as zero until the ring position has wrapped once
// in_stall is high while a sample request is worked on or its result waits for room
// ----------------------------------------------------------------------------
module ir_wall_sensing #(
  parameter int TABLE_LEN = 16,
  parameter int AVG_DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_table_select,
  input  logic [3:0]  in_table_index,
  input  logic [11:0] in_table_value,
  input  logic [11:0] in_sample_front_left,
  input  logic [11:0] in_sample_front_right,
  input  logic [11:0] in_sample_left,
  input  logic [11:0] in_sample_right,
  input  logic [1:0]  in_control_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_dist_front_left,
  output logic [11:0] out_dist_front_right,
  output logic [11:0] out_dist_left,
  output logic [11:0] out_dist_right,
  output logic [3:0]  out_wall_flags,
  output logic [1:0]  out_side_control_flags,
  output logic signed [12:0] out_error_left,
  output logic signed [12:0] out_error_right
);
  import iws_pkg::*;

  localparam int TIDX_W  = $clog2(TABLE_LEN);
  localparam int RAW_AW  = $clog2(4 * TABLE_LEN);
  localparam int LEN_AW  = $clog2(2 * TABLE_LEN);
  localparam int HIST_AW = $clog2(4 * AVG_DEPTH);
  localparam int POS_W   = $clog2(AVG_DEPTH);
  localparam int SUM_W   = SMP_W + $clog2(AVG_DEPTH);
  localparam int RCP_SH  = SUM_W + $clog2(AVG_DEPTH);
  localparam int PROD_W  = SUM_W + RCP_SH;

  // reciprocal of the averaging depth, rounded up
  localparam logic [RCP_SH-1:0] AVG_RCP =
    RCP_SH'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HRD   = 5'd1;
  localparam logic [4:0] S_HUPD  = 5'd2;
  localparam logic [4:0] S_CVST  = 5'd3;
  localparam logic [4:0] S_R0    = 5'd5;
  localparam logic [4:0] S_R0W   = 5'd6;
  localparam logic [4:0] S_RL    = 5'd7;
  localparam logic [4:0] S_RLW   = 5'd8;
  localparam logic [4:0] S_SCAN  = 5'd9;
  localparam logic [4:0] S_SCANW = 5'd10;
  localparam logic [4:0] S_LC    = 5'd11;
  localparam logic [4:0] S_LCW   = 5'd12;
  localparam logic [4:0] S_LA    = 5'd13;
  localparam logic [4:0] S_LAW   = 5'd14;
  localparam logic [4:0] S_LB    = 5'd15;
  localparam logic [4:0] S_LBW   = 5'd16;
  localparam logic [4:0] S_MUL   = 5'd17;
  localparam logic [4:0] S_DIVS  = 5'd18;
  localparam logic [4:0] S_DIVW  = 5'd19;
  localparam logic [4:0] S_NEXT  = 5'd20;
  localparam logic [4:0] S_POST  = 5'd21;

  logic [SMP_W-1:0] raw_mem  [4*TABLE_LEN];
  logic [LEN_W-1:0] len_mem  [2*TABLE_LEN];
  logic [SMP_W-1:0] hist_mem [4*AVG_DEPTH];

  logic [SMP_W-1:0] front_thr_r, side_thr_r;
  logic [4:0]       st_r;
  logic [1:0]       h_r;
  logic [2:0]       conv_r;
  logic [TIDX_W-1:0] c_r;
  logic [POS_W-1:0] pos_r;
  logic             hist_full_r;
  logic [SUM_W-1:0] sum_r [4];
  logic [SMP_W-1:0] smp_r [4];
  logic [SMP_W-1:0] dist_r [4];
  logic [SMP_W-1:0] avgd_r [4];
  logic [1:0]       mode_r;
  logic [SMP_W-1:0] val_r, hi_r, lo_r, m_r, n_r;
  logic [LEN_W-1:0] la_r;
  logic [19:0]      p1_r, p2_r;
  logic [SMP_W-1:0] raw_q, hist_q;
  logic [LEN_W-1:0] len_q, lb_r;
  logic [7:0]       cnt_r [2];
  logic             ctl_r [2];
  logic [ERR_W-1:0] err_r [2];
  logic             out_valid_r;
  logic [SMP_W-1:0] o_dist_r [4];
  logic [3:0]       o_flags_r;
  logic [1:0]       o_ctl_r;
  logic [ERR_W-1:0] o_err_r [2];

  div_req_t dreq;
  div_rsp_t drsp;

  logic [1:0]        ch;
  logic [RAW_AW-1:0] raw_addr, raw_waddr;
  logic [LEN_AW-1:0] len_addr, len_waddr;
  logic [HIST_AW-1:0] hist_addr;
  logic              in_acc, cfg_wr, out_free;
  logic [POS_W-1:0]  pos_inc;
  logic [SMP_W-1:0]  res_val;
  logic [SMP_W:0]    seg_d;
  logic [PROD_W-1:0] avg_prod;
  logic [SMP_W-1:0]  avg_q;
  logic [3:0]        flags;
  logic [7:0]        cnt_new [2];
  logic              act [2];
  logic [ERR_W-1:0]  errv [2];

  iws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign ch        = conv_r[1:0];
  assign raw_addr  = RAW_AW'(ch) * RAW_AW'(TABLE_LEN) + RAW_AW'(c_r);
  assign len_addr  = (ch[1] ? LEN_AW'(TABLE_LEN) : '0) + LEN_AW'(c_r);
  assign hist_addr = HIST_AW'(h_r) * HIST_AW'(AVG_DEPTH) + HIST_AW'(pos_r);
  assign raw_waddr = RAW_AW'(in_table_select[1:0]) * RAW_AW'(TABLE_LEN)
                   + RAW_AW'(in_table_index);
  assign len_waddr = (in_table_select == SEL_SIDE_LEN ? LEN_AW'(TABLE_LEN) : '0)
                   + LEN_AW'(in_table_index);
  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign out_free  = !(out_valid_r && out_stall);
  assign pos_inc   = (32'(pos_r) + 1 >= AVG_DEPTH) ? '0 : pos_r + 1'b1;
  assign seg_d     = {1'b0, m_r} + {1'b0, n_r};
  assign avg_prod  = PROD_W'(sum_r[ch]) * PROD_W'(AVG_RCP);
  assign avg_q     = avg_prod[RCP_SH +: SMP_W];

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_FRONT_THR: prdata = 32'(front_thr_r);
      REG_SIDE_THR:  prdata = 32'(side_thr_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    dreq = '0;
    if (st_r == S_DIVS) begin
      dreq.start = 1'b1;
      dreq.num   = NUM_W'({(21'(p1_r) + 21'(p2_r)), 4'b0000}) + NUM_W'(seg_d[SMP_W:1]);
      dreq.den   = seg_d[DEN_W-1:0];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    raw_q  <= raw_mem[raw_addr];
    len_q  <= len_mem[len_addr];
    hist_q <= hist_mem[hist_addr];
    if (in_acc && in_req_type == REQ_TABLE && 32'(in_table_index) < TABLE_LEN) begin
      if (!in_table_select[2])
        raw_mem[raw_waddr] <= in_table_value;
      else if (in_table_select == SEL_FRONT_LEN || in_table_select == SEL_SIDE_LEN)
        len_mem[len_waddr] <= (in_table_value > 12'd255) ? 8'hff : in_table_value[7:0];
    end
    if (st_r == S_HUPD)
      hist_mem[hist_addr] <= smp_r[h_r];
  end

  // post-processing of one sample set
  always_comb begin
    flags[0] = dist_r[0] <= front_thr_r;
    flags[1] = dist_r[1] <= front_thr_r;
    flags[2] = dist_r[2] <= side_thr_r;
    flags[3] = dist_r[3] <= side_thr_r;
    for (int s = 0; s < 2; s++) begin
      logic [SMP_W-1:0] d, a, diff, lim;
      d    = dist_r[2+s];
      a    = avgd_r[2+s];
      diff = (d > a) ? d - a : a - d;
      cnt_new[s] = (flags[2+s] && diff < STABLE_DIFF)
                 ? ((cnt_r[s] == 8'hff) ? cnt_r[s] : cnt_r[s] + 1'b1) : 8'd0;
      lim = (cnt_new[s] > STABLE_MIN) ? side_thr_r : STRAIGHT_TARGET[SMP_W-1:0];
      act[s]  = ctl_r[s];
      errv[s] = err_r[s];
      if (mode_r == MODE_STRAIGHT) begin
        act[s]  = flags[2+s] && d <= lim
               && {1'b0, dist_r[s]} > ({1'b0, side_thr_r} + FRONT_MARGIN);
        errv[s] = act[s] ? {1'b0, d} - STRAIGHT_TARGET : '0;
      end else if (mode_r == MODE_DIAGONAL) begin
        act[s]  = flags[2+s] && d <= DIAG_TARGET[SMP_W-1:0] && dist_r[s] > DIAG_FRONT_MIN;
        errv[s] = act[s] ? {1'b0, d} - DIAG_TARGET : '0;
      end
    end
  end

  always_comb begin
    res_val = drsp.quo[SMP_W-1:0];
    if (st_r == S_LCW)
      res_val = {len_q, 4'b0000};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      front_thr_r <= FRONT_THR_RST;
      side_thr_r  <= SIDE_THR_RST;
      pos_r       <= '0;
      hist_full_r <= 1'b0;
      out_valid_r <= 1'b0;
      h_r         <= '0;
      conv_r      <= '0;
      c_r         <= '0;
      for (int i = 0; i < 4; i++) sum_r[i] <= '0;
      for (int s = 0; s < 2; s++) begin
        cnt_r[s] <= '0;
        ctl_r[s] <= 1'b0;
        err_r[s] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_FRONT_THR) front_thr_r <= pwdata[SMP_W-1:0];
        else                           side_thr_r  <= pwdata[SMP_W-1:0];
      end
      if (out_valid_r && !out_stall && st_r != S_POST)
        out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_acc && in_req_type == REQ_SAMPLE) begin
            pos_r <= pos_inc;
            h_r   <= '0;
            st_r  <= S_HRD;
          end
        end
        S_HRD: st_r <= S_HUPD;
        S_HUPD: begin
          sum_r[h_r] <= sum_r[h_r] - (hist_full_r ? SUM_W'(hist_q) : '0)
                      + SUM_W'(smp_r[h_r]);
          h_r <= h_r + 1'b1;
          if (h_r == 2'd3) begin
            if (pos_r == '0) hist_full_r <= 1'b1;
            conv_r <= '0;
            st_r   <= S_CVST;
          end else begin
            st_r <= S_HRD;
          end
        end
        S_CVST: begin
          c_r  <= '0;
          st_r <= S_R0;
        end
        S_R0:  st_r <= S_R0W;
        S_R0W: begin
          if (val_r >= raw_q) begin
            st_r <= S_LC;
          end else begin
            hi_r <= raw_q;
            c_r  <= TIDX_W'(TABLE_LEN - 1);
            st_r <= S_RL;
          end
        end
        S_RL:  st_r <= S_RLW;
        S_RLW: begin
          if (val_r <= raw_q) begin
            st_r <= S_LC;
          end else begin
            c_r  <= TIDX_W'(1);
            st_r <= S_SCAN;
          end
        end
        S_SCAN: st_r <= S_SCANW;
        S_SCANW: begin
          if (val_r > raw_q) begin
            lo_r <= raw_q;
            c_r  <= c_r - 1'b1;
            st_r <= S_LA;
          end else begin
            hi_r <= raw_q;
            c_r  <= c_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_LC:  st_r <= S_LCW;
        S_LCW: st_r <= S_NEXT;
        S_LA:  st_r <= S_LAW;
        S_LAW: begin
          la_r <= len_q;
          c_r  <= c_r + 1'b1;
          st_r <= S_LB;
        end
        S_LB:  st_r <= S_LBW;
        S_LBW: begin
          lb_r <= len_q;
          m_r  <= hi_r - val_r;
          n_r  <= val_r - lo_r;
          st_r <= S_MUL;
        end
        S_MUL: begin
          p1_r <= 20'(n_r) * 20'(la_r);
          p2_r <= 20'(m_r) * 20'(lb_r);
          st_r <= S_DIVS;
        end
        S_DIVS: st_r <= S_DIVW;
        S_DIVW: if (drsp.done) st_r <= S_NEXT;
        S_NEXT: begin
          conv_r <= conv_r + 1'b1;
          st_r   <= (conv_r == 3'd7) ? S_POST : S_CVST;
        end
        S_POST: begin
          if (out_free) begin
            for (int s = 0; s < 2; s++) begin
              cnt_r[s] <= cnt_new[s];
              ctl_r[s] <= act[s];
              err_r[s] <= errv[s];
            end
            out_valid_r <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == REQ_SAMPLE) begin
      smp_r[0] <= in_sample_front_left;
      smp_r[1] <= in_sample_front_right;
      smp_r[2] <= in_sample_left;
      smp_r[3] <= in_sample_right;
      mode_r   <= in_control_mode;
    end
    if (st_r == S_CVST)
      val_r <= conv_r[2] ? avg_q : smp_r[ch];
    if (st_r == S_LCW || (st_r == S_DIVW && drsp.done)) begin
      if (conv_r[2]) avgd_r[ch] <= res_val;
      else           dist_r[ch] <= res_val;
    end
    if (st_r == S_POST && out_free) begin
      for (int i = 0; i < 4; i++) o_dist_r[i] <= dist_r[i];
      o_flags_r <= flags;
      o_ctl_r   <= {act[1], act[0]};
      o_err_r[0] <= errv[0];
      o_err_r[1] <= errv[1];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_dist_front_left    = o_dist_r[0];
  assign out_dist_front_right   = o_dist_r[1];
  assign out_dist_left          = o_dist_r[2];
  assign out_dist_right         = o_dist_r[3];
  assign out_wall_flags         = o_flags_r;
  assign out_side_control_flags = o_ctl_r;
  assign out_error_left         = $signed(o_err_r[0]);
  assign out_error_right        = $signed(o_err_r[1]);

  a_scan_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SCANW |-> c_r != '0)
    else $error("segment scan at entry zero");

  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == S_POST)
    else $error("result raised outside post step");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == REQ_SAMPLE |=> st_r == S_HRD)
    else $error("sample request did not start");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> st_r == S_DIVW)
    else $error("divider finished with nobody waiting");

endmodule
